// ===== rtl/llvc_pkg.sv =====
// ----------------------------------------------------------------------------
// llvc_pkg
// Shared constants and types of the lane line vehicle counter.
// ----------------------------------------------------------------------------
package llvc_pkg;

	localparam int MAX_WIDTH   = 320;
	localparam int MAX_HEIGHT  = 256;
	localparam int MAX_LANES   = 4;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int LANE_W      = $clog2(MAX_LANES);

	localparam int BG_W  = 16;
	localparam int SUM_W = 25;
	localparam int CNT_W = 17;
	localparam int LVL_W = 8;
	localparam int TOT_W = 16;

	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 56;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;

	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [LVL_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== rtl/llvc_ram.sv =====
// ----------------------------------------------------------------------------
// llvc_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module llvc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/llvc_div.sv =====
// ----------------------------------------------------------------------------
// llvc_div
// Serial restoring divider that returns an eight-bit quotient clamped to
// its maximum, or zero for a zero divisor.
// ----------------------------------------------------------------------------
module llvc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  llvc_pkg::div_req_t  req,
	output llvc_pkg::div_rsp_t  rsp
);

	import llvc_pkg::*;

	localparam int STEP_W = $clog2(LVL_W);

	logic [SUM_W-1:0]  rem_q;
	logic [CNT_W-1:0]  div_q;
	logic [LVL_W-1:0]  quo_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic              sat_q;
	logic              zero_q;
	logic [SUM_W-1:0]  trial;

	assign trial = SUM_W'(div_q) << step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && step_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.dividend;
			div_q  <= req.divisor;
			quo_q  <= '0;
			step_q <= STEP_W'(LVL_W - 1);
			sat_q  <= req.dividend >= SUM_W'({req.divisor, LVL_W'(0)});
			zero_q <= req.divisor == '0;
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q         <= rem_q - trial;
				quo_q[step_q] <= 1'b1;
			end
			step_q <= step_q - 1'b1;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = zero_q ? '0 : (sat_q ? '1 : quo_q);

endmodule

// ===== rtl/lane_line_vehicle_counter.sv =====
// ----------------------------------------------------------------------------
// lane_line_vehicle_counter
// Background-subtraction vehicle counter on a virtual line of lanes.
// ----------------------------------------------------------------------------
// Pixels are taken at one per clock within a frame. The per-pixel background
// sits in one 81920 x 16 RAM that is read when a pixel is accepted and
// written back in the next cycle, with a forwarding register for back-to-back
// pixels at the same position; the RAM is not cleared, so the first frame
// after reset must cover every position that later frames use. After the
// last pixel of every frame but the first, the input stalls while a serial
// divider, one quotient bit per cycle, turns each lane's sum into its level.
// The result waits in an output register, so the next frame may start before
// it is taken.
module lane_line_vehicle_counter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [llvc_pkg::IN_DATA_W-1:0]  s_tdata,   // pixel, column, row
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [llvc_pkg::OUT_DATA_W-1:0] m_tdata,   // lane_hits, vehicle_total,
	                                                   // level_lane0..level_lane3
	input  logic                            cfg_we,
	input  logic [llvc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [llvc_pkg::CFG_DATA_W-1:0] cfg_data
);

	import llvc_pkg::*;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LANE_COUNT, CFG_FRAME_WIDTH, CFG_BAND_TOP, CFG_BAND_THICK,
		CFG_FG_THRESH, CFG_RISE_THRESH, CFG_QUIET_LIMIT
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DRAIN, ST_LANE, ST_DIVW, ST_PUBLISH
	} state_t;

	localparam int QUIET_PREV = 20;
	localparam int BG_GAIN    = 6554;
	localparam int GAIN_SHIFT = 16;
	localparam int FG_WEIGHT  = 255;
	localparam int DIV3_MUL   = 683;
	localparam int DIV3_SHIFT = 11;
	localparam logic [SUM_W-1:0] SUM_MAX = '1;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [TOT_W-1:0] TOT_MAX = '1;
	localparam logic signed [13:0] GAIN_S = 14'(BG_GAIN);

	function automatic logic [8:0] lane_bound(input logic [2:0] k, input logic [8:0] w,
		input logic [2:0] n);
		logic [10:0] x;
		logic [20:0] m;
		logic [8:0]  b;
		x = 11'(k) * 11'(w);
		m = 21'(x) * 21'(DIV3_MUL);
		case (n)
			3'd1:    b = 9'(x);
			3'd2:    b = 9'(x >> 1);
			3'd3:    b = 9'(m >> DIV3_SHIFT);
			3'd4:    b = 9'(x >> 2);
			default: b = '0;
		endcase
		return b;
	endfunction

	// Configuration registers.
	logic [2:0] lane_count_q;
	logic [8:0] frame_width_q;
	logic [7:0] band_top_q;
	logic [8:0] band_thick_q;
	logic [7:0] fg_thr_q;
	logic [7:0] rise_thr_q;
	logic [7:0] quiet_q;
	logic [2:0] n_active;
	logic [8:0] bound_q [MAX_LANES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_count_q  <= 3'd2;
			frame_width_q <= 9'd320;
			band_top_q    <= 8'd120;
			band_thick_q  <= 9'd5;
			fg_thr_q      <= 8'd28;
			rise_thr_q    <= '0;
			quiet_q       <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_LANE_COUNT:  lane_count_q  <= cfg_data[2:0];
				CFG_FRAME_WIDTH: frame_width_q <= cfg_data;
				CFG_BAND_TOP:    band_top_q    <= cfg_data[7:0];
				CFG_BAND_THICK:  band_thick_q  <= cfg_data;
				CFG_FG_THRESH:   fg_thr_q      <= cfg_data[7:0];
				CFG_RISE_THRESH: rise_thr_q    <= cfg_data[7:0];
				CFG_QUIET_LIMIT: quiet_q       <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign n_active = (lane_count_q == '0 || 32'(lane_count_q) > MAX_LANES) ? '0 : lane_count_q;

	always_ff @(posedge clk) begin
		for (int k = 0; k <= MAX_LANES; k++) begin
			bound_q[k] <= lane_bound(3'(k), frame_width_q, n_active);
		end
	end

	// Input side and background RAM.
	state_t            state_q, state_d;
	logic              accept;
	logic [7:0]        pix_in;
	logic [8:0]        col_in;
	logic [7:0]        row_in;
	logic [ADDR_W-1:0] addr_in;
	logic              store_in;
	logic              first_done_q;

	assign pix_in   = s_tdata[7:0];
	assign col_in   = s_tdata[16:8];
	assign row_in   = s_tdata[24:17];
	assign accept   = s_tvalid && s_tready;
	assign addr_in  = ADDR_W'(row_in) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_in);
	assign store_in = 12'(col_in) < 12'(MAX_WIDTH) && 12'(row_in) < 12'(MAX_HEIGHT);

	logic              valid_s1, load_s1, store_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [7:0]        pix_s1, row_s1;
	logic [8:0]        col_s1;
	logic [BG_W-1:0]   rd_data, bg_cur, bg_new;
	logic              ram_we;
	logic [BG_W-1:0]   ram_wdata;
	logic              wr_valid_q;
	logic [ADDR_W-1:0] wr_addr_q;
	logic [BG_W-1:0]   wr_data_q;

	llvc_ram #(.WIDTH(BG_W), .DEPTH(STORE_DEPTH)) u_bg_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_s1),
		.wdata (ram_wdata),
		.raddr (addr_in),
		.rdata (rd_data)
	);

	logic signed [16:0]  diff;
	logic [15:0]         abs_diff;
	logic signed [30:0]  prod;
	logic signed [17:0]  bg_sum;
	logic                fg;
	logic                in_lane, in_band;
	logic [LANE_W-1:0]   lane_s1;

	always_comb begin
		bg_cur   = (wr_valid_q && wr_addr_q == addr_s1) ? wr_data_q : rd_data;
		diff     = 17'({1'b0, pix_s1, 8'h00}) - 17'({1'b0, bg_cur});
		abs_diff = diff[16] ? 16'(-diff) : 16'(diff);
		fg       = abs_diff > {fg_thr_q, 8'h00};
		prod     = 31'(diff) * 31'(GAIN_S);
		bg_sum   = $signed({2'b00, bg_cur}) + 18'(prod >>> GAIN_SHIFT);
		bg_new   = bg_sum[BG_W-1:0];
		ram_we   = valid_s1 && store_s1;
		ram_wdata = load_s1 ? {pix_s1, 8'h00} : bg_new;
		in_lane  = 1'b0;
		lane_s1  = '0;
		for (int k = 0; k < MAX_LANES; k++) begin
			if (3'(k) < n_active && col_s1 >= bound_q[k] && col_s1 < bound_q[k+1]) begin
				in_lane = 1'b1;
				lane_s1 = LANE_W'(k);
			end
		end
		in_band = row_s1 >= band_top_q && 10'(row_s1) < 10'(band_top_q) + 10'(band_thick_q);
	end

	// Lane accumulation stage.
	logic              valid_s2, acc_s2, fg_s2;
	logic [LANE_W-1:0] lane_s2;
	logic [SUM_W-1:0]  sum_q [MAX_LANES];
	logic [CNT_W-1:0]  cnt_q [MAX_LANES];
	logic [SUM_W:0]    sum_add;

	assign sum_add = (SUM_W+1)'(sum_q[lane_s2]) + (fg_s2 ? (SUM_W+1)'(FG_WEIGHT) : '0);

	// End-of-frame sequencing.
	logic [2:0]        lane_q;
	logic [LANE_W-1:0] li;
	logic [LVL_W-1:0]  prev_q  [MAX_LANES];
	logic [LVL_W-1:0]  older_q [MAX_LANES];
	logic [LVL_W-1:0]  lvl_q   [MAX_LANES];
	logic [MAX_LANES-1:0] hits_q;
	logic [TOT_W-1:0]  total_q;
	logic              out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	div_req_t          div_req;
	div_rsp_t          div_rsp;
	logic              trig;
	logic              lane_go;

	assign li      = lane_q[LANE_W-1:0];
	assign lane_go = lane_q < n_active;

	llvc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		trig = div_rsp.quotient > rise_thr_q && div_rsp.quotient > prev_q[li]
			&& (div_rsp.quotient - prev_q[li]) > rise_thr_q
			&& 32'(prev_q[li]) < QUIET_PREV && older_q[li] < quiet_q;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid && s_tlast && first_done_q) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!valid_s1 && !valid_s2) state_d = ST_LANE;
			end
			ST_LANE: begin
				state_d = lane_go ? ST_DIVW : ST_PUBLISH;
			end
			ST_DIVW: begin
				if (div_rsp.done) state_d = ST_LANE;
			end
			ST_PUBLISH: begin
				if (!out_valid_q || m_tready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready         = state_q == ST_IDLE;
		div_req.start    = state_q == ST_LANE && lane_go;
		div_req.dividend = sum_q[li];
		div_req.divisor  = cnt_q[li];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			first_done_q <= 1'b0;
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			acc_s2       <= 1'b0;
			wr_valid_q   <= 1'b0;
			lane_q       <= '0;
			hits_q       <= '0;
			total_q      <= '0;
			out_valid_q  <= 1'b0;
			for (int k = 0; k < MAX_LANES; k++) begin
				sum_q[k]   <= '0;
				cnt_q[k]   <= '0;
				prev_q[k]  <= '0;
				older_q[k] <= '0;
				lvl_q[k]   <= '0;
			end
		end else begin
			state_q    <= state_d;
			valid_s1   <= accept;
			valid_s2   <= valid_s1;
			acc_s2     <= valid_s1 && store_s1 && !load_s1 && in_lane && in_band;
			wr_valid_q <= ram_we;
			if (accept && s_tlast && !first_done_q) begin
				first_done_q <= 1'b1;
			end
			if (acc_s2) begin
				sum_q[lane_s2] <= sum_add > (SUM_W+1)'(SUM_MAX) ? SUM_MAX : sum_add[SUM_W-1:0];
				if (cnt_q[lane_s2] != CNT_MAX) begin
					cnt_q[lane_s2] <= cnt_q[lane_s2] + 1'b1;
				end
			end
			if (state_q == ST_IDLE && state_d == ST_DRAIN) begin
				lane_q <= '0;
				hits_q <= '0;
				for (int k = 0; k < MAX_LANES; k++) begin
					lvl_q[k] <= '0;
				end
			end
			if (state_q == ST_DIVW && div_rsp.done) begin
				lane_q      <= lane_q + 1'b1;
				lvl_q[li]   <= div_rsp.quotient;
				prev_q[li]  <= div_rsp.quotient;
				older_q[li] <= prev_q[li];
				if (trig) begin
					hits_q[li] <= 1'b1;
					if (total_q != TOT_MAX) begin
						total_q <= total_q + 1'b1;
					end
				end
			end
			if (state_q == ST_PUBLISH && state_d == ST_IDLE) begin
				out_valid_q <= 1'b1;
				for (int k = 0; k < MAX_LANES; k++) begin
					sum_q[k] <= '0;
					cnt_q[k] <= '0;
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			load_s1  <= !first_done_q;
			store_s1 <= store_in;
			addr_s1  <= addr_in;
			pix_s1   <= pix_in;
			col_s1   <= col_in;
			row_s1   <= row_in;
		end
		wr_addr_q <= addr_s1;
		wr_data_q <= ram_wdata;
		lane_s2   <= lane_s1;
		fg_s2     <= fg;
		if (state_q == ST_PUBLISH && state_d == ST_IDLE) begin
			out_data_q <= {4'b0000, lvl_q[3], lvl_q[2], lvl_q[1], lvl_q[0], total_q, hits_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	ap_frame_end_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tlast && first_done_q) |=> state_q == ST_DRAIN)
		else $error("frame end did not start the drain");

	ap_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LANE || state_q == ST_DIVW) |-> (!valid_s1 && !valid_s2 && !acc_s2))
		else $error("lane evaluation overlaps pixel accumulation");

	ap_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUBLISH && out_valid_q && !m_tready)
		|=> (state_q == ST_PUBLISH && $stable(out_data_q)))
		else $error("pending result overwritten");

	ap_total_mono: assert property (@(posedge clk) disable iff (!arst_n)
		total_q >= $past(total_q))
		else $error("vehicle total decreased");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the lane line vehicle counter.
// ----------------------------------------------------------------------------
// One load frame fills the background at a fixed grid of positions. Later
// frames use only those positions, plus pixels outside the store. A model in
// the bench tracks the background, the lane sums and the trigger history, and
// predicts each frame result. The output checker compares every result
// transfer with the oldest prediction, field by field. Directed frames cover
// the field extremes and the corner settings. Random frames follow, made of
// quiet, busy and noisy frames under changing register settings and under
// three patterns of idling on the two streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
	import llvc_pkg::*;

	localparam int CYCLE_LIMIT       = 200_000;
	localparam int SETTLE_CYCLES     = 64;
	localparam int ITEMS_PER_PHASE   = 150;
	localparam int QUIET_PREV        = 20;
	localparam int BG_GAIN           = 6554;
	localparam int unsigned SUM_MAX  = (1 << SUM_W) - 1;
	localparam int unsigned CNT_MAX  = (1 << CNT_W) - 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LANE_COUNT     = 3'd0,
		REG_FRAME_WIDTH    = 3'd1,
		REG_BAND_TOP       = 3'd2,
		REG_BAND_THICKNESS = 3'd3,
		REG_FG_THRESHOLD   = 3'd4,
		REG_RISE_THRESHOLD = 3'd5,
		REG_QUIET_LIMIT    = 3'd6,
		REG_SPARE          = 3'd7
	} cfg_reg_e;

	typedef enum int {FRAME_QUIET, FRAME_BUSY, FRAME_NOISE} frame_kind_e;

	typedef struct packed {
		logic [2:0] lane_count;
		logic [8:0] frame_width;
		logic [7:0] band_top;
		logic [8:0] band_thickness;
		logic [7:0] fg_threshold;
		logic [7:0] rise_threshold;
		logic [7:0] quiet_limit;
	} cfg_t;

	typedef struct packed {
		logic [MAX_LANES-1:0][LVL_W-1:0] levels;
		logic [TOT_W-1:0]                vehicle_total;
		logic [MAX_LANES-1:0]            lane_hits;
	} frame_result_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic                  s_tlast   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	cfg_t cur_cfg = '{lane_count: 3'd2, frame_width: 9'd320, band_top: 8'd120,
		band_thickness: 9'd5, fg_threshold: 8'd28, rise_threshold: 8'd0, quiet_limit: 8'd0};

	logic [BG_W-1:0] bg_mem [STORE_DEPTH];
	logic            background_loaded = 1'b0;
	int unsigned     lane_sum [MAX_LANES];
	int unsigned     lane_cnt [MAX_LANES];
	int              prev_level [MAX_LANES];
	int              older_level [MAX_LANES];
	int              vehicle_total = 0;

	frame_result_t frame_results_q [$];

	int load_cols [$] = '{0, 1, 2, 3, 4, 5, 6, 7, 20, 40, 60, 80, 100, 120, 140, 160, 180,
		200, 220, 240, 255, 256, 260, 280, 300, 318, 319};
	int load_rows [$] = '{0, 1, 2, 3, 64, 118, 119, 120, 121, 122, 123, 124, 127, 128, 200,
		254, 255};

	int src_idle_pct     = 20;
	int sink_idle_pct    = 76;
	int err_count        = 0;
	int cycle_count      = 0;
	int pixels_sent      = 0;
	int frames_checked   = 0;
	int settings_applied = 0;
	int vehicles_seen    = 0;

	lane_line_vehicle_counter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Run stopped at the cycle limit with %0d frame results outstanding.",
				frame_results_q.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic void track_pixel(input logic [7:0] pix, input logic [8:0] col,
			input logic [7:0] row, input logic last);
		int addr, p, bg, d, ad, q, n, w, lo, hi, lane, top, bottom, lvl, rise;
		int unsigned s;
		logic fg;
		frame_result_t res;
		n = (cur_cfg.lane_count == 0 || cur_cfg.lane_count > MAX_LANES) ? 0 : cur_cfg.lane_count;
		w = cur_cfg.frame_width;
		if (col < MAX_WIDTH && row < MAX_HEIGHT) begin
			addr = row * MAX_WIDTH + col;
			p = pix * 256;
			if (!background_loaded) begin
				bg_mem[addr] = 16'(p);
			end else begin
				bg = bg_mem[addr];
				d = p - bg;
				ad = (d < 0) ? -d : d;
				fg = ad > cur_cfg.fg_threshold * 256;
				q = (d * BG_GAIN) >>> 16;
				bg_mem[addr] = 16'(bg + q);
				lane = -1;
				for (int k = 0; k < n; k++) begin
					lo = (k * w) / n;
					hi = ((k + 1) * w) / n;
					if (col >= lo && col < hi)
						lane = k;
				end
				top = cur_cfg.band_top;
				bottom = top + cur_cfg.band_thickness;
				if (lane >= 0 && row >= top && row < bottom) begin
					s = lane_sum[lane] + (fg ? 255 : 0);
					lane_sum[lane] = (s > SUM_MAX) ? SUM_MAX : s;
					if (lane_cnt[lane] < CNT_MAX)
						lane_cnt[lane]++;
				end
			end
		end
		if (last && !background_loaded) begin
			background_loaded = 1'b1;
		end else if (last) begin
			res = '0;
			for (int k = 0; k < n; k++) begin
				lvl = (lane_cnt[k] != 0) ? lane_sum[k] / lane_cnt[k] : 0;
				if (lvl > 255)
					lvl = 255;
				rise = lvl - prev_level[k];
				if (lvl > cur_cfg.rise_threshold && rise > cur_cfg.rise_threshold &&
						prev_level[k] < QUIET_PREV && older_level[k] < cur_cfg.quiet_limit) begin
					res.lane_hits[k] = 1'b1;
					if (vehicle_total < 65535)
						vehicle_total++;
					vehicles_seen++;
				end
				older_level[k] = prev_level[k];
				prev_level[k] = lvl;
				res.levels[k] = 8'(lvl);
			end
			for (int k = 0; k < MAX_LANES; k++) begin
				lane_sum[k] = 0;
				lane_cnt[k] = 0;
			end
			res.vehicle_total = 16'(vehicle_total);
			frame_results_q.push_back(res);
		end
	endfunction

	always @(negedge clk)
		m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);

	always @(posedge clk) begin : result_check
		frame_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[$bits(frame_result_t)-1:0];
			if (frame_results_q.size() == 0) begin
				$error("Result transfer with no frame result pending: %h", m_tdata);
				err_count++;
			end else begin
				want = frame_results_q.pop_front();
				frames_checked++;
				if (got.lane_hits !== want.lane_hits) begin
					$error("lane_hits: expected %h, got %h", want.lane_hits, got.lane_hits);
					err_count++;
				end
				if (got.vehicle_total !== want.vehicle_total) begin
					$error("vehicle_total: expected %0d, got %0d", want.vehicle_total,
						got.vehicle_total);
					err_count++;
				end
				for (int k = 0; k < MAX_LANES; k++) begin
					if (got.levels[k] !== want.levels[k]) begin
						$error("level_lane%0d: expected %0d, got %0d", k, want.levels[k],
							got.levels[k]);
						err_count++;
					end
				end
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_pixel(input logic [7:0] pix, input logic [8:0] col,
			input logic [7:0] row, input logic last);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, row, col, pix};
		s_tlast  <= last;
		do @(posedge clk); while (s_tready !== 1'b1);
		track_pixel(pix, col, row, last);
		pixels_sent++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (frame_results_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apply_settings(input cfg_t s);
		logic [CFG_DATA_W-1:0] val;
		drain_results();
		for (int i = REG_LANE_COUNT; i <= REG_SPARE; i++) begin
			case (cfg_reg_e'(i))
				REG_LANE_COUNT:     val = s.lane_count;
				REG_FRAME_WIDTH:    val = s.frame_width;
				REG_BAND_TOP:       val = s.band_top;
				REG_BAND_THICKNESS: val = s.band_thickness;
				REG_FG_THRESHOLD:   val = s.fg_threshold;
				REG_RISE_THRESHOLD: val = s.rise_threshold;
				REG_QUIET_LIMIT:    val = s.quiet_limit;
				default:            val = 9'($urandom_range(0, 511));
			endcase
			cfg_we    <= 1'b1;
			cfg_index <= cfg_reg_e'(i);
			cfg_data  <= val;
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		cur_cfg = s;
		settings_applied++;
	endtask

	// The load frame writes every position that later frames may read.
	task automatic test_background_load();
		foreach (load_rows[r]) begin
			foreach (load_cols[c]) begin
				if ($urandom_range(0, 19) == 0)
					send_pixel(8'($urandom), 9'($urandom_range(320, 511)), 8'($urandom), 1'b0);
				send_pixel(8'($urandom), 9'(load_cols[c]), 8'(load_rows[r]), 1'b0);
			end
		end
		send_pixel(8'($urandom), 9'd511, 8'd255, 1'b1);
		drain_results();
	endtask

	task automatic test_reset_settings();
		send_pixel(8'd255, 9'd0, 8'd120, 1'b0);
		send_pixel(8'd0, 9'd319, 8'd124, 1'b0);
		send_pixel(8'd255, 9'd160, 8'd122, 1'b0);
		send_pixel(8'd7, 9'd511, 8'd255, 1'b1);
		drain_results();
		send_pixel(8'd0, 9'd0, 8'd120, 1'b0);
		send_pixel(8'd255, 9'd0, 8'd120, 1'b0);
		send_pixel(8'd128, 9'd319, 8'd255, 1'b1);
	endtask

	task automatic test_extreme_settings();
		apply_settings('{lane_count: 3'd0, frame_width: 9'd0, band_top: 8'd0,
			band_thickness: 9'd0, fg_threshold: 8'd0, rise_threshold: 8'd0, quiet_limit: 8'd0});
		send_pixel(8'd255, 9'd0, 8'd0, 1'b0);
		send_pixel(8'd0, 9'd319, 8'd255, 1'b1);
		apply_settings('{lane_count: 3'd7, frame_width: 9'd511, band_top: 8'd255,
			band_thickness: 9'd511, fg_threshold: 8'd255, rise_threshold: 8'd255,
			quiet_limit: 8'd255});
		send_pixel(8'd255, 9'd318, 8'd255, 1'b0);
		send_pixel(8'd0, 9'd256, 8'd255, 1'b1);
	endtask

	task automatic test_lane_edges();
		apply_settings('{lane_count: 3'd4, frame_width: 9'd320, band_top: 8'd118,
			band_thickness: 9'd12, fg_threshold: 8'd0, rise_threshold: 8'd0,
			quiet_limit: 8'd255});
		send_pixel(8'd255, 9'd0, 8'd120, 1'b0);
		send_pixel(8'd255, 9'd80, 8'd121, 1'b0);
		send_pixel(8'd0, 9'd240, 8'd122, 1'b0);
		send_pixel(8'd255, 9'd319, 8'd123, 1'b1);
		apply_settings('{lane_count: 3'd1, frame_width: 9'd100, band_top: 8'd0,
			band_thickness: 9'd256, fg_threshold: 8'd0, rise_threshold: 8'd0,
			quiet_limit: 8'd255});
		send_pixel(8'd255, 9'd200, 8'd0, 1'b0);
		send_pixel(8'd255, 9'd0, 8'd255, 1'b0);
		send_pixel(8'd255, 9'd0, 8'd255, 1'b1);
	endtask

	// Frames are mostly quiet or busy runs over the band, so that lanes
	// build the quiet history and the jump that a trigger needs.
	task automatic test_random_traffic();
		cfg_t s;
		frame_kind_e kind;
		logic [8:0] col;
		logic [7:0] row, pix, bgp;
		int nb, sent, frames, r;
		int band_rows [$];
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin src_idle_pct = 20; sink_idle_pct = 76; end
				1: begin src_idle_pct = 76; sink_idle_pct = 20; end
				default: begin src_idle_pct = 0; sink_idle_pct = 0; end
			endcase
			sent = 0;
			frames = 0;
			while (sent < ITEMS_PER_PHASE) begin
				if (frames % 6 == 0) begin
					r = $urandom_range(0, 19);
					s.lane_count = (r == 0) ? 3'd0 : (r == 1) ? 3'($urandom_range(5, 7)) :
						3'($urandom_range(1, 4));
					r = $urandom_range(0, 19);
					s.frame_width = (r == 0) ? 9'd0 : (r == 1) ? 9'($urandom_range(321, 511)) :
						(r == 2) ? 9'($urandom_range(1, 8)) :
						(r < 10) ? 9'd320 : 9'($urandom_range(1, 320));
					s.band_top = 8'(load_rows[$urandom_range(0, load_rows.size() - 1)]);
					r = $urandom_range(0, 19);
					s.band_thickness = (r == 0) ? 9'd0 : (r == 1) ? 9'($urandom_range(256, 511)) :
						9'($urandom_range(1, 70));
					r = $urandom_range(0, 19);
					s.fg_threshold = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 :
						8'($urandom_range(5, 80));
					r = $urandom_range(0, 19);
					s.rise_threshold = (r == 0) ? 8'd255 : 8'($urandom_range(0, 60));
					r = $urandom_range(0, 19);
					s.quiet_limit = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 :
						8'($urandom_range(20, 255));
					apply_settings(s);
					band_rows = {};
					foreach (load_rows[i])
						if (load_rows[i] >= s.band_top && load_rows[i] < s.band_top + s.band_thickness)
							band_rows.push_back(load_rows[i]);
				end
				r = $urandom_range(0, 99);
				kind = (r < 45) ? FRAME_QUIET : (r < 80) ? FRAME_BUSY : FRAME_NOISE;
				nb = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 8);
				for (int i = 0; i < nb; i++) begin
					if ($urandom_range(0, 9) == 0) begin
						col = 9'($urandom_range(MAX_WIDTH, 511));
						row = 8'($urandom);
					end else if (i == 0 || $urandom_range(0, 9) != 0) begin
						col = 9'(load_cols[$urandom_range(0, load_cols.size() - 1)]);
						if (band_rows.size() != 0 && $urandom_range(0, 99) < 80)
							row = 8'(band_rows[$urandom_range(0, band_rows.size() - 1)]);
						else
							row = 8'(load_rows[$urandom_range(0, load_rows.size() - 1)]);
					end
					if (col < MAX_WIDTH) begin
						bgp = bg_mem[row * MAX_WIDTH + col][15:8];
						sent++;
					end else begin
						bgp = 8'($urandom);
					end
					case (kind)
						FRAME_QUIET: pix = bgp;
						FRAME_BUSY:  pix = (bgp >= 128) ? 8'($urandom_range(0, 20)) :
							8'($urandom_range(235, 255));
						default:     pix = 8'($urandom);
					endcase
					send_pixel(pix, col, row, i == nb - 1);
				end
				frames++;
			end
		end
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_background_load();
		test_reset_settings();
		test_extreme_settings();
		test_lane_edges();
		test_random_traffic();
		drain_results();
		$display("Checked %0d frame results from %0d pixels under %0d register settings.",
			frames_checked, pixels_sent, settings_applied);
		$display("Predicted %0d lane triggers; idling ran at 20/76, 76/20 and 0/0 percent.",
			vehicles_seen);
		if (err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
